// ----- hdl/rsl_pkg.sv -----
// Shared constants and types for the run-slice line rasterizer.
`timescale 1ns / 1ps

package rsl_pkg;

    // coordinate width of every endpoint and pixel
    localparam int CB = 6;
    // width of distances plus one (dmax+1, dmin+1, quotient, remainder)
    localparam int DW = CB + 1;
    // divider step counter width
    localparam int DCW = $clog2(DW + 1);

    // stream data widths, rounded up to whole bytes
    localparam int IN_W  = ((4 * CB + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CB + 7) / 8) * 8;

    typedef logic [CB-1:0] coord_t;
    typedef logic [DW-1:0] dist_t;

    // ordered line description, start point has the smaller x
    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t dmax;
        coord_t dmin;
        logic   shallow;
        logic   down;
    } line_t;

    // divider result bundle
    typedef struct packed {
        logic  done;
        dist_t quot;
        dist_t rem;
    } div_res_t;

endpackage

// ----- hdl/rsl_setup.sv -----
// Line setup: start point choice, deltas, major/minor axis and direction.
`timescale 1ns / 1ps

module rsl_setup (
    input  rsl_pkg::coord_t x_start,
    input  rsl_pkg::coord_t y_start,
    input  rsl_pkg::coord_t x_end,
    input  rsl_pkg::coord_t y_end,
    output rsl_pkg::line_t  line
);
    import rsl_pkg::*;

    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t dx;
    coord_t ady;
    logic   down;
    logic   shallow;

    // start from the endpoint with the smaller x; equal x starts at the end point
    always_comb
    begin
        if (x_end > x_start)
        begin
            x0 = x_start;
            y0 = y_start;
            x1 = x_end;
            y1 = y_end;
        end
        else
        begin
            x0 = x_end;
            y0 = y_end;
            x1 = x_start;
            y1 = y_start;
        end
    end

    // deltas and axis selection; a tie counts as steep
    always_comb
    begin
        dx      = x1 - x0;
        down    = y1 < y0;
        ady     = down ? (y0 - y1) : (y1 - y0);
        shallow = dx > ady;
    end

    assign line.x0      = x0;
    assign line.y0      = y0;
    assign line.dmax    = shallow ? dx : ady;
    assign line.dmin    = shallow ? ady : dx;
    assign line.shallow = shallow;
    assign line.down    = down;

endmodule

// ----- hdl/rsl_div.sv -----
// Iterative restoring divider, one quotient bit per cycle on a shared subtractor.
`timescale 1ns / 1ps

module rsl_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rsl_pkg::dist_t    dividend,
    input  rsl_pkg::dist_t    divisor,
    output rsl_pkg::div_res_t res
);
    import rsl_pkg::*;

    logic [DCW-1:0] cnt_reg;
    logic [DCW-1:0] cnt_next;
    logic           done_reg;
    logic           done_next;
    dist_t          rem_reg;
    dist_t          rem_next;
    dist_t          quot_reg;
    dist_t          quot_next;
    dist_t          den_reg;
    dist_t          den_next;

    logic [DW:0]    rsh;
    logic [DW+1:0]  diff;
    logic           ge;

    // one trial subtraction per step
    always_comb
    begin
        rsh  = {rem_reg, quot_reg[DW-1]};
        diff = {1'b0, rsh} - {2'b00, den_reg};
        ge   = !diff[DW+1];
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next  = DCW'(DW);
            rem_next  = '0;
            quot_next = dividend;
            den_next  = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            rem_next  = ge ? diff[DW-1:0] : rsh[DW-1:0];
            quot_next = {quot_reg[DW-2:0], ge};
            done_next = (cnt_reg == DCW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

// ----- hdl/run_slice_line_raster.sv -----
// Run-slice line rasterizer top level: setup, divider and pixel sequencer.
//
//  channel | dir | tdata (low bit up)                     | tlast      | tuser
//  --------+-----+----------------------------------------+------------+------
//  s_*     | in  | x_start, y_start, x_end, y_end          | -          | -
//  m_*     | out | pixel_x, pixel_y                        | last_pixel | -
//
// A line is accepted, then passes through the 7-step divider that forms run
// length and remainder, then is emitted as dmax+1 pixels, one pixel per cycle
// when m_tready is high.
// s_tready is high only when idle. m_tready low holds the current pixel.
// Reset (rst_n low, asynchronous) returns the sequencer to idle.
`timescale 1ns / 1ps

module run_slice_line_raster (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [rsl_pkg::IN_W-1:0] s_tdata,   // x_start, y_start, x_end, y_end
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [rsl_pkg::OUT_W-1:0] m_tdata,  // pixel_x, pixel_y
    output logic                    m_tlast     // last_pixel
);
    import rsl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t   state_reg;
    state_t   state_next;
    line_t    line_reg;
    line_t    line_next;
    line_t    setup_line;
    div_res_t div_res;

    dist_t    base_reg;
    dist_t    base_next;
    dist_t    r_reg;
    dist_t    r_next;
    dist_t    acc_reg;
    dist_t    acc_next;
    dist_t    cnt_reg;
    dist_t    cnt_next;
    coord_t   n_reg;
    coord_t   n_next;
    coord_t   cx_reg;
    coord_t   cx_next;
    coord_t   cy_reg;
    coord_t   cy_next;
    logic     last_reg;
    logic     last_next;

    logic     in_acc;
    logic     out_acc;
    dist_t    m_cnt;
    dist_t    sum;
    logic     wrap;
    coord_t   cy_step;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // endpoint ordering and deltas
    rsl_setup u_setup (
        .x_start (s_tdata[CB-1:0]),
        .y_start (s_tdata[2*CB-1:CB]),
        .x_end   (s_tdata[3*CB-1:2*CB]),
        .y_end   (s_tdata[4*CB-1:3*CB]),
        .line    (setup_line)
    );

    // (dmax+1) / (dmin+1) and remainder
    rsl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc),
        .dividend (DW'(setup_line.dmax) + DW'(1)),
        .divisor  (DW'(setup_line.dmin) + DW'(1)),
        .res      (div_res)
    );

    // run length spread: run i is one longer when i*r mod m + r reaches m
    always_comb
    begin
        m_cnt   = DW'(line_reg.dmin) + DW'(1);
        sum     = acc_reg + r_reg;
        wrap    = sum >= m_cnt;
        cy_step = line_reg.down ? (cy_reg - 1'b1) : (cy_reg + 1'b1);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        line_next  = line_reg;
        base_next  = base_reg;
        r_next     = r_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    line_next  = setup_line;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    base_next  = div_res.quot;
                    r_next     = div_res.rem;
                    acc_next   = div_res.rem;
                    cnt_next   = div_res.quot - 1'b1;
                    n_next     = '0;
                    cx_next    = line_reg.x0;
                    cy_next    = line_reg.y0;
                    last_next  = (line_reg.dmax == '0);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_acc)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        n_next    = n_reg + 1'b1;
                        last_next = ((n_reg + 1'b1) == line_reg.dmax);
                        if (cnt_reg != '0)
                        begin
                            // major step inside the run
                            cnt_next = cnt_reg - 1'b1;
                            if (line_reg.shallow)
                                cx_next = cx_reg + 1'b1;
                            else
                                cy_next = cy_step;
                        end
                        else
                        begin
                            // new run: minor step plus first major step
                            cx_next  = cx_reg + 1'b1;
                            cy_next  = cy_step;
                            cnt_next = wrap ? base_reg : (base_reg - 1'b1);
                            acc_next = wrap ? (sum - m_cnt) : sum;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            line_reg  <= '0;
            base_reg  <= '0;
            r_reg     <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            n_reg     <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            line_reg  <= line_next;
            base_reg  <= base_next;
            r_reg     <= r_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            last_reg  <= last_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_EMIT);
    assign m_tdata  = OUT_W'({cy_reg, cx_reg});
    assign m_tlast  = last_reg;

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a line is being emitted");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("accepted line did not enter the divide phase");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("output continued after the last pixel");

endmodule
